[hw/rtl/cle_pkg.sv]
// package for the c literal escape encoder
// holds the item descriptor passed from front to back, character constants and codes
// no dependencies
package cle_pkg;

    localparam int unsigned MAX_OUT = 8;   // most result bytes one item can cause
    localparam int unsigned IDX_W   = 3;   // index into the result bytes of one item

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;

    // index 0 holds '0', index 15 holds 'F'
    localparam logic [15:0][7:0] HEX_DIGITS = "FEDCBA9876543210";

    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_ESC,
        KIND_NEWLINE,
        KIND_HEX
    } kind_t;

    // one classified item, fully expanded into result bytes
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] chars;     // result bytes, first in index 0
        logic [IDX_W-1:0]        last_idx;  // index of the final result byte
        logic                    closes;    // final byte is the closing quote
    } desc_t;

endpackage

[hw/rtl/cle_front.sv]
// front end: accepts input items, classifies each byte and expands it into a descriptor
// depends on cle_pkg
module cle_front
    import cle_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tlast,   // last_byte
    input  logic [1:0] s_tuser,   // [0] first_byte, [1] empty_string
    input  logic       fifo_full,
    output logic       push,
    output desc_t      push_data
);

    kind_t                   kind;
    logic [7:0]              letter;
    logic [MAX_OUT-1:0][7:0] body;
    logic [IDX_W-1:0]        body_len;
    logic [IDX_W-1:0]        pos;
    logic                    first_b;
    logic                    empty_s;

    assign first_b  = s_tuser[0];
    assign empty_s  = s_tuser[1];
    assign s_tready = !fifo_full;
    assign push     = s_tvalid && !fifo_full;

    // classify the byte
    always_comb
    begin
        kind   = KIND_PLAIN;
        letter = s_tdata;
        unique case (s_tdata)
            CH_BEL:    begin kind = KIND_ESC; letter = "a"; end
            CH_BS:     begin kind = KIND_ESC; letter = "b"; end
            CH_FF:     begin kind = KIND_ESC; letter = "f"; end
            CH_CR:     begin kind = KIND_ESC; letter = "r"; end
            CH_TAB:    begin kind = KIND_ESC; letter = "t"; end
            CH_VT:     begin kind = KIND_ESC; letter = "v"; end
            CH_QUOTE,
            CH_APOS,
            CH_BSLASH: begin kind = KIND_ESC; letter = s_tdata; end
            CH_LF:     begin kind = KIND_NEWLINE; letter = "n"; end
            default:
            begin
                if (s_tdata >= CH_PRINT_LO && s_tdata <= CH_PRINT_HI)
                    kind = KIND_PLAIN;
                else
                    kind = KIND_HEX;
            end
        endcase
    end

    // escape body without the framing quotes
    always_comb
    begin
        body     = '0;
        body_len = IDX_W'(1);
        unique case (kind)
            KIND_PLAIN:
            begin
                body[0]  = s_tdata;
                body_len = IDX_W'(1);
            end
            KIND_ESC:
            begin
                body[0]  = CH_BSLASH;
                body[1]  = letter;
                body_len = IDX_W'(2);
            end
            KIND_NEWLINE:
            begin
                body[0]  = CH_BSLASH;
                body[1]  = letter;
                body[2]  = CH_QUOTE;
                body[3]  = CH_LF;
                body[4]  = CH_QUOTE;
                body_len = IDX_W'(5);
            end
            KIND_HEX:
            begin
                body[0]  = CH_BSLASH;
                body[1]  = "x";
                body[2]  = HEX_DIGITS[s_tdata[7:4]];
                body[3]  = HEX_DIGITS[s_tdata[3:0]];
                body[4]  = CH_QUOTE;
                body[5]  = CH_QUOTE;
                body_len = IDX_W'(6);
            end
            default:
            begin
                body[0]  = s_tdata;
                body_len = IDX_W'(1);
            end
        endcase
    end

    // add the opening and closing quotes
    always_comb
    begin
        pos       = body_len + {{(IDX_W-1){1'b0}}, first_b};
        push_data = '0;
        if (empty_s)
        begin
            push_data.chars[0] = CH_QUOTE;
            push_data.chars[1] = CH_QUOTE;
            push_data.last_idx = IDX_W'(1);
            push_data.closes   = 1'b1;
        end
        else
        begin
            push_data.chars = first_b ? {body[MAX_OUT-2:0], CH_QUOTE} : body;
            if (s_tlast)
                push_data.chars[pos] = CH_QUOTE;
            push_data.last_idx = pos + {{(IDX_W-1){1'b0}}, s_tlast} - IDX_W'(1);
            push_data.closes   = s_tlast;
        end
    end

endmodule

[hw/rtl/cle_fifo.sv]
// short descriptor queue between front and back
// depends on cle_pkg
module cle_fifo
    import cle_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_data,
    output logic  full,
    input  logic  pop,
    output desc_t head,
    output logic  empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    desc_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[hw/rtl/cle_back.sv]
// back end: walks the queue head one result byte per cycle, unless the output stalls, into the output register
// depends on cle_pkg
module cle_back
    import cle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  desc_t      head,
    input  logic       fifo_empty,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // run_end
    output logic [0:0] m_tuser    // [0] string_end
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       data_reg;
    logic             last_reg;
    logic             send_end_reg;
    logic             advance;
    logic             at_end;

    assign advance = !fifo_empty && (!valid_reg || m_tready);
    assign at_end  = (idx_reg == head.last_idx);
    assign pop     = advance && at_end;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            idx_next   = at_end ? '0 : idx_reg + IDX_W'(1);
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg     <= head.chars[idx_reg];
            last_reg     <= at_end;
            send_end_reg <= at_end && head.closes;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = data_reg;
    assign m_tlast    = last_reg;
    assign m_tuser[0] = send_end_reg;

endmodule

[hw/rtl/c_literal_escape_encoder.sv]
// c literal escape encoder: one raw string byte per input item, quoted literal text out
// an accepted item is written into the queue, then its first result byte into the output register
// throughput: one result byte per cycle from the back end unless the output stalls, so plain
// printable bytes sustain one input item per cycle; escapes stall input once the queue fills
// reset: asynchronous active-low rst_n empties the queue and drops the output valid
// depends on cle_pkg, cle_front, cle_fifo, cle_back
module c_literal_escape_encoder
    import cle_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 4   // descriptors buffered between front and back
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input items
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    input  logic [1:0] s_tuser,   // [0] first_byte, [1] empty_string
    // result items
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_end
    output logic [0:0] m_tuser    // [0] string_end
);

    // the front classifies a byte in the accept cycle and writes the whole
    // expansion (up to eight bytes plus the index of the final one) into the queue
    desc_t push_data;
    desc_t head;
    logic  push;
    logic  pop;
    logic  fifo_full;
    logic  fifo_empty;

    cle_front u_front
    (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .push      (push),
        .push_data (push_data)
    );

    // queue lets the input keep flowing while a long escape drains
    cle_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .head      (head),
        .empty     (fifo_empty)
    );

    // back end steps through the head descriptor, one byte per cycle unless the output stalls,
    // into an output register that refills in the same cycle it is taken
    cle_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

[hw/rtl/cle_checker.sv]
// port-level checks for the c literal escape encoder
// depends on the top level's clock, reset and result ports only; bound to c_literal_escape_encoder
module cle_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);

    // string end only on the last byte of a run
    a_end_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("string_end without run_end");

    // the literal always closes on a quote
    a_end_is_quote: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'h22)
        else $error("string_end on a byte that is not a quote");

    // escaped text is printable or the line feed of a split newline
    a_text_printable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >= 8'h20 && m_tdata <= 8'h7E) || m_tdata == 8'h0A)
        else $error("unescaped byte on output");

    // a stalled result holds
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("output changed while stalled");

endmodule

bind c_literal_escape_encoder cle_checker u_cle_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
